[hdl/vslt_pkg.sv]
// ----------------------------------------------------------------------------
// vslt_pkg
// Shared types and constants of the video stream loss tracker.
// ----------------------------------------------------------------------------
package vslt_pkg;

  localparam int FN_BITS  = 24;
  localparam int CNT_BITS = 32;
  localparam int SEQ_BITS = 16;
  localparam int ORD_W    = FN_BITS + 2;   // signed encoding order / frame refs
  localparam int LOST_W   = 24;
  localparam int NB_W     = 4;
  localparam int GOP_W    = 8;
  localparam int TC_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_B_FRAMES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_CNT  = 2'd2;

  localparam logic [NB_W-1:0]  NB_RESET  = 4'd2;
  localparam logic [GOP_W-1:0] GOP_RESET = 8'd12;
  localparam logic [TC_W-1:0]  TC_RESET  = 24'd65535;

  localparam logic [1:0] KIND_I   = 2'd0;
  localparam logic [1:0] KIND_IDR = 2'd1;
  localparam logic [1:0] KIND_P   = 2'd2;
  localparam logic [1:0] KIND_B   = 2'd3;

  typedef logic signed [ORD_W-1:0] ord_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq_number;
    logic                frag_start;
    logic                frag_end;
    logic [FN_BITS-1:0]  frame_number;
    logic [1:0]          frame_kind;
    logic                warmup_over;
  } in_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] packets_lost_now;
    logic [LOST_W-1:0]   frames_lost_now;
    logic                frame_completed;
    logic [CNT_BITS-1:0] packets_received_total;
    logic [CNT_BITS-1:0] packets_lost_total;
    logic [CNT_BITS-1:0] frames_received_total;
    logic [CNT_BITS-1:0] frames_discarded_total;
  } out_t;

  // classified packet handed from front to back
  typedef struct packed {
    in_t  pkt;
    ord_t enc;
    ord_t prev_ref;
    ord_t next_ref;
    logic gop_edge;
  } work_t;

endpackage

[hdl/vslt_divu.sv]
// ----------------------------------------------------------------------------
// vslt_divu
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vslt_divu #(
  parameter int W = vslt_pkg::ORD_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q, dvs_q;
  logic [W:0]    shifted, diff;
  logic          take;

  // shifted can only overflow W bits when it is already >= divisor
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule

[hdl/vslt_front.sv]
// ----------------------------------------------------------------------------
// vslt_front
// Accepts packets and works out encoding order and B-frame reference slots.
// ----------------------------------------------------------------------------
module vslt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  vslt_pkg::in_t               in_data_i,
  input  logic [vslt_pkg::NB_W-1:0]   nb_i,
  input  logic [vslt_pkg::GOP_W-1:0]  gop_i,
  output logic                        push_o,
  input  logic                        full_i,
  output vslt_pkg::work_t             work_o
);
  localparam int W = vslt_pkg::ORD_W;

  typedef enum logic [2:0] {F_IDLE, F_DIV1, F_MUL, F_START2, F_DIV2, F_PUSH} fstate_e;

  fstate_e             state_q;
  vslt_pkg::in_t       item_q;
  logic [W-1:0]        quot_q, prev_q;
  logic                edge_q;
  logic                accept, start;
  logic [W-1:0]        dividend, divisor, nbp1, gop_ext, next_ref;
  logic                div_done;
  logic [W-1:0]        div_quot, div_rem;
  vslt_pkg::ord_t      f_s, enc;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign nbp1       = W'(nb_i) + W'(1);
  assign gop_ext    = (gop_i == '0) ? W'(1) : W'(gop_i);
  assign next_ref   = prev_q + nbp1;
  assign start      = accept || (state_q == F_START2);
  assign dividend   = (state_q == F_IDLE) ? W'(in_data_i.frame_number) : next_ref;
  assign divisor    = (state_q == F_IDLE) ? nbp1 : gop_ext;

  vslt_divu #(.W(W)) u_div (
    .clk_i, .rst_ni,
    .start_i(start), .dividend_i(dividend), .divisor_i(divisor),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE:   if (accept) state_q <= F_DIV1;
        F_DIV1:   if (div_done) state_q <= F_MUL;
        F_MUL:    state_q <= F_START2;
        F_START2: state_q <= F_DIV2;
        F_DIV2:   if (div_done) state_q <= F_PUSH;
        F_PUSH:   if (!full_i) state_q <= F_IDLE;
        default:  state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == F_DIV1 && div_done) quot_q <= div_quot;
    if (state_q == F_MUL) prev_q <= W'(quot_q * nbp1);
    if (state_q == F_DIV2 && div_done) edge_q <= (div_rem == '0);
  end

  // encoding order: B is frame+1, I/IDR frame 0 is 0, else frame-b
  always_comb begin
    f_s = vslt_pkg::ord_t'(item_q.frame_number);
    if (item_q.frame_kind == vslt_pkg::KIND_B)
      enc = f_s + vslt_pkg::ord_t'(1);
    else if (item_q.frame_kind == vslt_pkg::KIND_P || f_s != '0)
      enc = f_s - vslt_pkg::ord_t'(nb_i);
    else
      enc = '0;
  end

  assign push_o          = (state_q == F_PUSH) && !full_i;
  assign work_o.pkt      = item_q;
  assign work_o.enc      = enc;
  assign work_o.prev_ref = prev_q;
  assign work_o.next_ref = next_ref;
  assign work_o.gop_edge = edge_q;
endmodule

[hdl/vslt_queue.sv]
// ----------------------------------------------------------------------------
// vslt_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module vslt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vslt_pkg::work_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vslt_pkg::work_t rdata_o
);
  vslt_pkg::work_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end
endmodule

[hdl/vslt_back.sv]
// ----------------------------------------------------------------------------
// vslt_back
// Stream state update, loss and dependency checks, counters, result register.
// ----------------------------------------------------------------------------
module vslt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  vslt_pkg::work_t            work_i,
  output logic                       pop_o,
  input  logic [vslt_pkg::NB_W-1:0]  nb_i,
  input  logic [vslt_pkg::TC_W-1:0]  tc_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output vslt_pkg::out_t             out_data_o
);
  localparam int W  = vslt_pkg::ORD_W;
  localparam int CW = vslt_pkg::CNT_BITS;
  localparam int SW = vslt_pkg::SEQ_BITS;
  typedef logic signed [W:0] wide_t;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_EXEC} bstate_e;

  bstate_e             state_q;
  logic                started_q, done_q, drop_q;
  logic [SW-1:0]       last_seq_q;
  vslt_pkg::ord_t      lgi_q, lgp_q, open_num_q, open_ord_q;
  logic [CW-1:0]       c_pr_q, c_pl_q, c_fr_q, c_fd_q;
  logic [W-1:0]        rem_q;
  logic                out_valid_q;
  vslt_pkg::out_t      out_q;

  vslt_pkg::ord_t      x_ord, mod_val;
  logic [W-1:0]        x_mag, tc_ext, div_quot, div_rem;
  logic                div_start, div_done, fire;

  // next-state values
  logic                started_d, done_d, drop_d, done_now, pass, intra, gap;
  logic [SW-1:0]       last_seq_d, pk_lost;
  vslt_pkg::ord_t      lgi_d, lgp_d, open_num_d, open_ord_d, f_s, p_ref;
  wide_t               fr, d;
  logic [vslt_pkg::LOST_W-1:0] fr_sat;
  logic [CW-1:0]       c_pr_d, c_pl_d, c_fr_d, c_fd_d;
  vslt_pkg::in_t       pk;

  assign tc_ext    = (tc_i == '0) ? W'(1) : W'(tc_i);
  assign x_ord     = open_ord_q + vslt_pkg::ord_t'(1);
  assign x_mag     = x_ord[W-1] ? W'(-x_ord) : W'(x_ord);
  assign div_start = (state_q == B_IDLE) && !empty_i;
  assign fire      = (state_q == B_EXEC) && (!out_valid_q || out_ready_i);
  assign pop_o     = fire;

  vslt_divu #(.W(W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(x_mag), .divisor_i(tc_ext),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  always_comb begin
    pk         = work_i.pkt;
    f_s        = vslt_pkg::ord_t'(pk.frame_number);
    intra      = (pk.frame_kind == vslt_pkg::KIND_I) || (pk.frame_kind == vslt_pkg::KIND_IDR);
    p_ref      = f_s - vslt_pkg::ord_t'(nb_i) - vslt_pkg::ord_t'(1);
    mod_val    = x_ord[W-1] ? -vslt_pkg::ord_t'(rem_q) : vslt_pkg::ord_t'(rem_q);
    started_d  = started_q;
    done_d     = done_q;
    drop_d     = drop_q;
    last_seq_d = last_seq_q;
    lgi_d      = lgi_q;
    lgp_d      = lgp_q;
    open_num_d = open_num_q;
    open_ord_d = open_ord_q;
    c_pr_d     = c_pr_q;
    c_pl_d     = c_pl_q;
    c_fd_d     = c_fd_q;
    pk_lost    = '0;
    fr         = '0;
    d          = '0;
    done_now   = 1'b0;
    pass       = 1'b0;
    gap        = 1'b0;

    if (!started_q) begin
      if (pk.warmup_over && intra && pk.frag_start) begin
        last_seq_d = pk.seq_number;
        lgp_d      = (f_s != '0) ? p_ref : vslt_pkg::ord_t'(-1);
        open_num_d = f_s;
        open_ord_d = work_i.enc;
        if (pk.frag_end) begin
          done_d   = 1'b1;
          lgi_d    = f_s;
          done_now = 1'b1;
        end else begin
          drop_d = 1'b0;
          done_d = 1'b0;
          lgi_d  = vslt_pkg::ord_t'(-1);
        end
        c_pr_d    = c_pr_q + 1'b1;
        started_d = 1'b1;
      end
    end else begin
      gap = (pk.seq_number != last_seq_q + 1'b1);
      if (gap) begin
        pk_lost = pk.seq_number - last_seq_q - 1'b1;
        if (work_i.enc > mod_val) begin
          d = wide_t'(work_i.enc) - wide_t'(open_ord_q) - wide_t'(1);
          if (work_i.enc <= open_ord_q) d = d + wide_t'(tc_ext);
          if (d > 0) fr = d;
        end
        if (!done_q) fr = fr + wide_t'(1);
        if (!pk.frag_start) drop_d = 1'b1;
      end
      last_seq_d = pk.seq_number;

      if (pk.frag_start) begin
        if (intra)
          pass = 1'b1;
        else if (pk.frame_kind == vslt_pkg::KIND_P)
          pass = (lgi_q == p_ref) || (lgp_q == p_ref);
        else if (work_i.gop_edge)
          pass = (lgp_q == work_i.prev_ref) && (lgi_q == work_i.next_ref);
        else
          pass = (lgp_q == work_i.next_ref);
        if (pass) begin
          if (pk.frag_end) begin
            done_d   = 1'b1;
            done_now = 1'b1;
            if (intra) lgi_d = f_s;
            else if (pk.frame_kind == vslt_pkg::KIND_P) begin
              lgp_d  = f_s;
              drop_d = 1'b0;
            end
          end else begin
            drop_d = 1'b0;
            done_d = 1'b0;
          end
        end else begin
          drop_d = 1'b1;
          done_d = pk.frag_end;
          if (pk.frag_end) fr = fr + wide_t'(1);
        end
        open_num_d = f_s;
        open_ord_d = work_i.enc;
      end else if (pk.frag_end) begin
        // drop_d, not drop_q: a gap on this packet marks the frame dropped
        if (!drop_d) begin
          if (intra) lgi_d = open_num_q;
          else if (pk.frame_kind == vslt_pkg::KIND_P) lgp_d = open_num_q;
          done_now = 1'b1;
        end else begin
          fr = fr + wide_t'(1);
        end
        done_d = 1'b1;
      end
      c_pr_d = c_pr_q + 1'b1;
    end

    fr_sat = (fr > wide_t'({vslt_pkg::LOST_W{1'b1}})) ? '1 : fr[vslt_pkg::LOST_W-1:0];
    c_pl_d = c_pl_q + CW'(pk_lost);
    c_fd_d = c_fd_q + CW'(fr_sat);
    c_fr_d = c_fr_q + CW'(done_now);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      started_q   <= 1'b0;
      done_q      <= 1'b1;
      drop_q      <= 1'b0;
      last_seq_q  <= '0;
      lgi_q       <= vslt_pkg::ord_t'(-1);
      lgp_q       <= vslt_pkg::ord_t'(-1);
      open_num_q  <= '0;
      open_ord_q  <= '0;
      c_pr_q      <= '0;
      c_pl_q      <= '0;
      c_fr_q      <= '0;
      c_fd_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !fire) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: if (div_start) state_q <= B_DIV;
        B_DIV:  if (div_done) state_q <= B_EXEC;
        B_EXEC: begin
          if (fire) begin
            state_q     <= B_IDLE;
            out_valid_q <= 1'b1;
            started_q   <= started_d;
            done_q      <= done_d;
            drop_q      <= drop_d;
            last_seq_q  <= last_seq_d;
            lgi_q       <= lgi_d;
            lgp_q       <= lgp_d;
            open_num_q  <= open_num_d;
            open_ord_q  <= open_ord_d;
            c_pr_q      <= c_pr_d;
            c_pl_q      <= c_pl_d;
            c_fr_q      <= c_fr_d;
            c_fd_q      <= c_fd_d;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_DIV && div_done) rem_q <= div_rem;
    if (fire) begin
      out_q.packets_lost_now       <= pk_lost;
      out_q.frames_lost_now        <= fr_sat;
      out_q.frame_completed        <= done_now;
      out_q.packets_received_total <= c_pr_d;
      out_q.packets_lost_total     <= c_pl_d;
      out_q.frames_received_total  <= c_fr_d;
      out_q.frames_discarded_total <= c_fd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

[hdl/video_stream_loss_tracker.sv]
// ----------------------------------------------------------------------------
// video_stream_loss_tracker
// Receive-side packet/frame loss and I/P/B dependency tracker.
// ----------------------------------------------------------------------------
// Each packet passes the front, the two-entry queue and the back, then the
//   result register, which holds while it waits on out_ready_i.
// The front takes a new packet only after its two serial
//   26-bit divides (frame / (b+1), next reference mod group size) and its push.
// Back runs one serial divide per packet, overlapped with the front.
// Reset: asynchronous, active low; registers take their defaults, tracking
//   waits for warm-up and an I/IDR first fragment. No clearing pass.
module video_stream_loss_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vslt_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output vslt_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [vslt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vslt_pkg::TC_W-1:0]        cfg_data_i
);
  // configuration registers
  logic [vslt_pkg::NB_W-1:0]  nb_q;
  logic [vslt_pkg::GOP_W-1:0] gop_q;
  logic [vslt_pkg::TC_W-1:0]  tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q  <= vslt_pkg::NB_RESET;
      gop_q <= vslt_pkg::GOP_RESET;
      tc_q  <= vslt_pkg::TC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vslt_pkg::CFG_B_FRAMES:   nb_q  <= cfg_data_i[vslt_pkg::NB_W-1:0];
        vslt_pkg::CFG_GROUP_SIZE: gop_q <= cfg_data_i[vslt_pkg::GOP_W-1:0];
        vslt_pkg::CFG_TRACE_CNT:  tc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  logic            push, full, pop, empty;
  vslt_pkg::work_t wr_work, rd_work;

  vslt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .nb_i(nb_q), .gop_i(gop_q),
    .push_o(push), .full_i(full), .work_o(wr_work)
  );

  vslt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(wr_work), .full_o(full),
    .pop_i(pop), .empty_o(empty), .rdata_o(rd_work)
  );

  vslt_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .work_i(rd_work), .pop_o(pop),
    .nb_i(nb_q), .tc_i(tc_q),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - video_stream_loss_tracker testbench
// Sends directed and random packet streams through the tracker while changing
// the configuration between phases. Each report is compared, field by field,
// with the one predicted by the loss scoreboard. Both handshakes stall at
// random.
// ----------------------------------------------------------------------------
module tb;

  // Predicts the per-packet loss report and checks the block's reports in order.
  class loss_scoreboard;
    longint nb_cfg, gop_cfg, tc_cfg;
    bit               started, open_done, open_drop;
    logic [15:0]      last_seq;
    longint           good_intra, good_pred, open_num, open_ord;
    logic [31:0]      pkts_rx, pkts_lost, frames_rx, frames_disc;
    vslt_pkg::out_t   expected_reports[$];
    int               errors;

    function new();
      nb_cfg = vslt_pkg::NB_RESET; gop_cfg = vslt_pkg::GOP_RESET;
      tc_cfg = vslt_pkg::TC_RESET;
      started = 0; last_seq = 0; good_intra = -1; good_pred = -1;
      open_num = 0; open_ord = 0; open_done = 1; open_drop = 0;
      pkts_rx = 0; pkts_lost = 0; frames_rx = 0; frames_disc = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [vslt_pkg::CFG_IDX_W-1:0] idx,
                          logic [vslt_pkg::TC_W-1:0] val);
      case (idx)
        vslt_pkg::CFG_B_FRAMES:   nb_cfg  = val[vslt_pkg::NB_W-1:0];
        vslt_pkg::CFG_GROUP_SIZE: gop_cfg = val[vslt_pkg::GOP_W-1:0];
        vslt_pkg::CFG_TRACE_CNT:  tc_cfg  = val;
        default: ;
      endcase
    endfunction

    // Updates the tracking state for one accepted packet and queues its report.
    function void note_packet(vslt_pkg::in_t p);
      longint f, nb, tc, gop, enc, d, lost_frames, prev_ref, next_ref;
      logic [15:0] lost_pkts;
      bit intra, completed, pass;
      vslt_pkg::out_t r;
      f = p.frame_number; nb = nb_cfg;
      tc = (tc_cfg != 0) ? tc_cfg : 1;
      gop = (gop_cfg != 0) ? gop_cfg : 1;
      // encoding order: B frames follow their next reference
      if (p.frame_kind == vslt_pkg::KIND_B) enc = f + 1;
      else if (p.frame_kind == vslt_pkg::KIND_P) enc = f - nb;
      else enc = (f == 0) ? 0 : f - nb;
      intra = (p.frame_kind == vslt_pkg::KIND_I) || (p.frame_kind == vslt_pkg::KIND_IDR);
      lost_pkts = 0; lost_frames = 0; completed = 0;

      if (!started) begin
        if (p.warmup_over && intra && p.frag_start) begin
          last_seq = p.seq_number;
          good_pred = (f > 0) ? f - nb - 1 : -1;
          open_num = f; open_ord = enc;
          if (p.frag_end) begin
            open_done = 1; good_intra = f; completed = 1;
          end else begin
            open_drop = 0; open_done = 0; good_intra = -1;
          end
          pkts_rx++;
          started = 1;
        end
      end else begin
        if (p.seq_number != last_seq + 16'd1) begin
          lost_pkts = p.seq_number - last_seq - 16'd1;
          if (enc > (open_ord + 1) % tc) begin
            d = enc - open_ord - 1;
            if (enc <= open_ord) d += tc;
            if (d > 0) lost_frames += d;
          end
          if (!open_done) lost_frames++;
          if (!p.frag_start) open_drop = 1;
        end
        last_seq = p.seq_number;

        if (p.frag_start) begin
          if (intra) begin
            pass = 1;
          end else if (p.frame_kind == vslt_pkg::KIND_P) begin
            pass = (good_intra == f - nb - 1) || (good_pred == f - nb - 1);
          end else begin
            prev_ref = (f / (nb + 1)) * (nb + 1);
            next_ref = prev_ref + nb + 1;
            if (next_ref % gop == 0) pass = (good_pred == prev_ref) && (good_intra == next_ref);
            else pass = (good_pred == next_ref);
          end
          if (pass) begin
            if (p.frag_end) begin
              open_done = 1;
              if (intra) good_intra = f;
              else if (p.frame_kind == vslt_pkg::KIND_P) good_pred = f;
              completed = 1;
              if (p.frame_kind == vslt_pkg::KIND_P) open_drop = 0;
            end else begin
              open_drop = 0; open_done = 0;
            end
          end else begin
            open_drop = 1;
            open_done = p.frag_end;
            if (p.frag_end) lost_frames++;
          end
          open_num = f; open_ord = enc;
        end else if (p.frag_end) begin
          if (!open_drop) begin
            if (intra) good_intra = open_num;
            else if (p.frame_kind == vslt_pkg::KIND_P) good_pred = open_num;
            completed = 1;
          end else begin
            lost_frames++;
          end
          open_done = 1;
        end

        if (lost_frames > 64'd16777215) lost_frames = 16777215;
        pkts_rx++;
        pkts_lost += lost_pkts;
        frames_disc += lost_frames[31:0];
      end
      if (completed) frames_rx++;

      r.packets_lost_now       = lost_pkts;
      r.frames_lost_now        = lost_frames[vslt_pkg::LOST_W-1:0];
      r.frame_completed        = completed;
      r.packets_received_total = pkts_rx;
      r.packets_lost_total     = pkts_lost;
      r.frames_received_total  = frames_rx;
      r.frames_discarded_total = frames_disc;
      expected_reports.insert(expected_reports.size(), r);
    endfunction

    function void show(string name, longint e, longint a);
      if (e != a) $display("  %s: expected %0d, got %0d", name, e, a);
    endfunction

    function void check_report(vslt_pkg::out_t a);
      vslt_pkg::out_t e;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report at %0t", $realtime);
        return;
      end
      e = expected_reports.pop_front();
      if (a !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("report mismatch at %0t", $realtime);
          show("packets_lost_now", e.packets_lost_now, a.packets_lost_now);
          show("frames_lost_now", e.frames_lost_now, a.frames_lost_now);
          show("frame_completed", e.frame_completed, a.frame_completed);
          show("packets_received_total", e.packets_received_total, a.packets_received_total);
          show("packets_lost_total", e.packets_lost_total, a.packets_lost_total);
          show("frames_received_total", e.frames_received_total, a.frames_received_total);
          show("frames_discarded_total", e.frames_discarded_total, a.frames_discarded_total);
        end
      end
    endfunction
  endclass

  logic                           clk_i = 0;
  logic                           rst_ni = 0;
  logic                           in_valid_i = 0;
  logic                           in_ready_o;
  vslt_pkg::in_t                  in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 0;
  vslt_pkg::out_t                 out_data_o;
  logic                           cfg_we_i = 0;
  logic [vslt_pkg::CFG_IDX_W-1:0] cfg_idx_i = vslt_pkg::CFG_B_FRAMES;
  logic [vslt_pkg::TC_W-1:0]      cfg_data_i = '0;

  loss_scoreboard sb = new();
  int tx_idle_pct, rx_idle_pct;   // chance of a stall cycle on each side
  logic [15:0] next_seq;          // sequence counter of the generated stream

  video_stream_loss_tracker uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // receiver side: random back-pressure, every accepted report is checked
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_report(out_data_o);
  end

  // Holds the packet until the transaction completes, then maybe idles.
  task automatic send_packet(vslt_pkg::in_t p);
    in_valid_i <= 1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_packet(p);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_fields(logic [15:0] seq, bit fs, bit fe, logic [23:0] fn,
                             logic [1:0] kind, bit warm);
    vslt_pkg::in_t p;
    p.seq_number = seq; p.frag_start = fs; p.frag_end = fe;
    p.frame_number = fn; p.frame_kind = kind; p.warmup_over = warm;
    send_packet(p);
  endtask

  // Waits until the block has drained, then writes all three registers.
  task automatic configure(logic [vslt_pkg::TC_W-1:0] nb, logic [vslt_pkg::TC_W-1:0] gop,
                           logic [vslt_pkg::TC_W-1:0] tc);
    in_valid_i <= 0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= vslt_pkg::CFG_B_FRAMES; cfg_data_i <= nb;
    @(posedge clk_i);
    sb.set_reg(vslt_pkg::CFG_B_FRAMES, nb);
    cfg_idx_i <= vslt_pkg::CFG_GROUP_SIZE; cfg_data_i <= gop;
    @(posedge clk_i);
    sb.set_reg(vslt_pkg::CFG_GROUP_SIZE, gop);
    cfg_idx_i <= vslt_pkg::CFG_TRACE_CNT; cfg_data_i <= tc;
    @(posedge clk_i);
    sb.set_reg(vslt_pkg::CFG_TRACE_CNT, tc);
    cfg_we_i <= 0;
  endtask

  // One fragmented frame with occasional lost fragments and corrupt packets.
  task automatic send_frame(longint fn, logic [1:0] kind, ref int sent);
    int frags;
    vslt_pkg::in_t p;
    frags = $urandom_range(1, 3);
    if ($urandom_range(99) < 3) begin
      next_seq += frags[15:0];    // whole frame lost on the wire
      return;
    end
    for (int i = 0; i < frags; i++) begin
      if ($urandom_range(99) < 4) begin
        next_seq++;
        continue;
      end
      p.seq_number = next_seq; p.frag_start = (i == 0); p.frag_end = (i == frags - 1);
      p.frame_number = fn[23:0]; p.frame_kind = kind;
      p.warmup_over = ($urandom_range(99) >= 2);
      if ($urandom_range(99) < 5) p = vslt_pkg::in_t'({$urandom, $urandom});
      send_packet(p);
      sent++;
      next_seq++;
    end
  endtask

  // Stream in decode order: reference frame, then the B frames before it.
  task automatic run_stream(int n_items);
    int sent, gop;
    longint nb, ref_fn, base;
    logic [1:0] kind;
    sent = 0;
    nb = sb.nb_cfg;
    gop = (sb.gop_cfg != 0) ? int'(sb.gop_cfg) : 1;
    base = ($urandom_range(9) == 0) ? 16777215 - 300 : 0;
    for (longint r = 0; sent < n_items; r++) begin
      ref_fn = base + r * (nb + 1);
      if (ref_fn % gop == 0) kind = $urandom_range(1) ? vslt_pkg::KIND_IDR : vslt_pkg::KIND_I;
      else kind = vslt_pkg::KIND_P;
      send_frame(ref_fn, kind, sent);
      if (r > 0)
        for (longint b = ref_fn - nb; b < ref_fn; b++) send_frame(b, vslt_pkg::KIND_B, sent);
    end
  endtask

  initial begin
    tx_idle_pct = 23; rx_idle_pct = 65;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // waiting phase: no warm-up, wrong kind, not a first fragment
    send_fields(16'd10, 1, 1, 24'd0, vslt_pkg::KIND_I, 0);
    send_fields(16'd11, 1, 1, 24'd3, vslt_pkg::KIND_P, 1);
    send_fields(16'd12, 0, 1, 24'd0, vslt_pkg::KIND_I, 1);
    // tracking starts on a fragmented I frame
    send_fields(16'd100, 1, 0, 24'd0, vslt_pkg::KIND_I, 1);
    send_fields(16'd101, 0, 1, 24'd0, vslt_pkg::KIND_I, 1);
    send_fields(16'd102, 1, 1, 24'd3, vslt_pkg::KIND_P, 1);
    send_fields(16'd103, 1, 1, 24'd1, vslt_pkg::KIND_B, 1);
    send_fields(16'd105, 1, 1, 24'd2, vslt_pkg::KIND_B, 1);      // one packet missing
    send_fields(16'd105, 1, 1, 24'd2, vslt_pkg::KIND_B, 1);      // repeated sequence number
    send_fields(16'd106, 1, 1, 24'd9, vslt_pkg::KIND_P, 1);      // frames skipped
    send_fields(16'd107, 1, 0, 24'd12, vslt_pkg::KIND_IDR, 1);
    send_fields(16'd109, 0, 1, 24'd12, vslt_pkg::KIND_IDR, 1);   // fragment lost, frame dropped
    send_fields(16'd110, 1, 1, 24'hFFFFFF, vslt_pkg::KIND_B, 1);
    send_fields(16'd111, 1, 1, 24'hFFFFFF, vslt_pkg::KIND_I, 1);
    send_fields(16'hFFFF, 1, 0, 24'd15, vslt_pkg::KIND_P, 1);    // huge gap, open frame
    send_fields(16'h0000, 0, 0, 24'd15, vslt_pkg::KIND_P, 1);    // sequence wraps
    send_fields(16'h0001, 0, 1, 24'd15, vslt_pkg::KIND_P, 1);
    send_fields(16'h0002, 1, 1, 24'd0, vslt_pkg::KIND_P, 0);
    send_fields(16'h0003, 0, 0, 24'h800000, vslt_pkg::KIND_B, 1);
    next_seq = 16'h0004;

    run_stream(200);
    configure(0, 1, 1);
    run_stream(200);
    tx_idle_pct = 65; rx_idle_pct = 23;
    configure(15, 255, 24'hFFFFFF);
    run_stream(200);
    configure(1, 0, 0);                                  // zero group and trace count
    run_stream(200);
    tx_idle_pct = 0; rx_idle_pct = 0;
    configure(3, 8, 40);                                 // encoding order wraps often
    run_stream(200);
    configure(24'($urandom_range(15)), 24'($urandom_range(1, 255)),
              24'($urandom_range(1, 1000)));
    run_stream(200);

    in_valid_i <= 0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_reports.size() == 0)
      $display("video_stream_loss_tracker test passed");
    else
      $display("video_stream_loss_tracker test failed");
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #3ms;
    $display("video_stream_loss_tracker test failed");
    $finish;
  end

endmodule
